// ----- rtl/lzt_pkg.sv -----
// ----------------------------------------------------------------------------
// lzt_pkg
// Shared types and constants for the LZSS token decompressor: payload
// structs, stream phase codes, status codes and controller interface structs.
// ----------------------------------------------------------------------------
package lzt_pkg;

  // History ring geometry. The address arithmetic wraps naturally, so the
  // depth must stay a power of two.
  localparam int HIST_DEPTH = 128;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  // Token field masks.
  localparam logic [15:0] TOK_GAP_MASK = 16'hFC00;
  localparam logic [15:0] TOK_LEN_MASK = 16'h03E0;
  localparam logic [15:0] TOK_CNT_MASK = 16'h001F;

  // Stream phases. Codes below PH_TOK_LO select a header byte.
  localparam logic [2:0] PH_HDR0   = 3'd0;
  localparam logic [2:0] PH_TOK_LO = 3'd4;
  localparam logic [2:0] PH_TOK_HI = 3'd5;
  localparam logic [2:0] PH_RUN    = 3'd6;
  localparam logic [2:0] PH_LIT    = 3'd7;

  // Final status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVERRUN = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_TRUNC   = 2'd3;

  // Input request payload.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } lzt_in_t;

  // Output request payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic [1:0] status;
    logic       run_end;
  } lzt_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic step;
    logic cp_rd;
    logic cp_emit;
    logic run_emit;
    logic lit_emit;
    logic stat_emit;
  } lzt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] phase;
    logic       overrun;
    logic       tok_copy;
    logic       run_zero;
    logic       run_last;
    logic       cp_last;
    logic       last;
    logic       slot_free;
  } lzt_sts_t;

endpackage

// ----- rtl/lzss_token_decompressor.sv -----
// ----------------------------------------------------------------------------
// lzss_token_decompressor
// Byte-serial LZSS token decompressor with a 128-byte history ring.
//
//   Channel | Direction | Handshake              | Payload
//   in_     | input     | in_valid / in_ready    | lzt_in_t  (in_byte, is_last)
//   out_    | output    | out_valid / out_ready  | lzt_out_t (out_byte, is_data,
//           |           |                        |            status, run_end)
//
// A request is taken in the idle state and decoded in the next cycle, after which
// header, token and empty-run bytes are done. Each copied byte passes through
// the registered history read before it is emitted; run and literal bytes are
// emitted without it. A final byte adds a status result. Reset is synchronous;
// the history ring needs no clearing pass, as per-entry valid bits make
// unwritten entries read zero. A stalled output holds the controller in its
// emit state, and in_ready stays low until the current request is done.
// ----------------------------------------------------------------------------
module lzss_token_decompressor (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lzt_pkg::lzt_in_t  in_payload,
  output logic              out_valid,
  input  logic              out_ready,
  output lzt_pkg::lzt_out_t out_payload
);
  import lzt_pkg::*;

  lzt_cmd_t cmd;
  lzt_sts_t sts;

  // Sequencing.
  lzt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stream state, history and output register.
  lzt_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_payload  (in_payload),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

endmodule

// ----- rtl/lzt_ram.sv -----
// ----------------------------------------------------------------------------
// lzt_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module lzt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/lzt_ctrl.sv -----
// ----------------------------------------------------------------------------
// lzt_ctrl
// Controller state machine: sequences the acceptance of one input request,
// its decode step, and the emission of copy, run, literal and status results.
// ----------------------------------------------------------------------------
module lzt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lzt_pkg::lzt_sts_t sts,
  output lzt_pkg::lzt_cmd_t cmd
);
  import lzt_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PROC    = 3'd1;
  localparam logic [2:0] S_CP_RD   = 3'd2;
  localparam logic [2:0] S_CP_OUT  = 3'd3;
  localparam logic [2:0] S_RUN_OUT = 3'd4;
  localparam logic [2:0] S_LIT_OUT = 3'd5;
  localparam logic [2:0] S_STAT    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [2:0] done_state;

  // After the last result of a request, a final byte adds a status result.
  assign done_state = sts.last ? S_STAT : S_IDLE;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_PROC;
        end
      end
      S_PROC: begin
        if (sts.overrun) begin
          state_nxt = done_state;
        end else if (sts.phase == PH_RUN && !sts.run_zero) begin
          state_nxt = S_RUN_OUT;
        end else if (sts.phase == PH_LIT) begin
          state_nxt = S_LIT_OUT;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = sts.tok_copy ? S_CP_RD : done_state;
        end
      end
      S_CP_RD: begin
        cmd.cp_rd = 1'b1;
        state_nxt = S_CP_OUT;
      end
      S_CP_OUT: begin
        if (sts.slot_free) begin
          cmd.cp_emit = 1'b1;
          state_nxt   = sts.cp_last ? done_state : S_CP_RD;
        end
      end
      S_RUN_OUT: begin
        if (sts.slot_free) begin
          cmd.run_emit = 1'b1;
          if (sts.run_last) begin
            state_nxt = done_state;
          end
        end
      end
      S_LIT_OUT: begin
        if (sts.slot_free) begin
          cmd.lit_emit = 1'b1;
          state_nxt    = done_state;
        end
      end
      S_STAT: begin
        if (sts.slot_free) begin
          cmd.stat_emit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/lzt_dpath.sv -----
// ----------------------------------------------------------------------------
// lzt_dpath
// Datapath: input holding registers, stream header and token state, size
// accounting, the history ring with its valid bits, and the output register.
// ----------------------------------------------------------------------------
module lzt_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  lzt_pkg::lzt_in_t  in_payload,
  input  lzt_pkg::lzt_cmd_t cmd,
  output lzt_pkg::lzt_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output lzt_pkg::lzt_out_t out_payload
);
  import lzt_pkg::*;

  // Input holding registers.
  logic [7:0]  byte_r;
  logic        last_r;

  // Stream state.
  logic [2:0]  phase_r,    phase_nxt;
  logic [31:0] declared_r, declared_nxt;
  logic [32:0] produced_r, produced_nxt;
  logic [7:0]  tok_lo_r,   tok_lo_nxt;
  logic [5:0]  run_len_r,  run_len_nxt;
  logic [4:0]  lit_left_r, lit_left_nxt;
  logic [4:0]  cp_left_r,  cp_left_nxt;
  logic [6:0]  dist_r,     dist_nxt;
  logic        ovf_r,      ovf_nxt;
  logic [HIST_AW-1:0]    pos_r, pos_nxt;
  logic [HIST_DEPTH-1:0] hvalid_r, hvalid_nxt;
  logic        rd_valid_r;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  lzt_out_t    out_r, out_nxt;

  // Token decode.
  logic [15:0] tok;
  logic [5:0]  gap;
  logic [4:0]  len;
  logic [4:0]  cnt;
  logic        is_run;
  logic [5:0]  tok_size;
  logic [33:0] size_sum;
  logic        would_ovf;

  // History access.
  logic [HIST_AW-1:0] rd_addr;
  logic [7:0]         rd_data;
  logic               hist_we;
  logic [7:0]         emit_byte;
  logic [1:0]         fin_status;

  assign tok      = {byte_r, tok_lo_r};
  assign gap      = 6'((tok & TOK_GAP_MASK) >> 10);
  assign len      = 5'((tok & TOK_LEN_MASK) >> 5);
  assign cnt      = 5'(tok & TOK_CNT_MASK);
  assign is_run   = (len == 5'd0) && (cnt == 5'd0);
  assign tok_size = is_run ? gap : (6'(len) + 6'(cnt));

  // Overrun check against the declared size.
  assign size_sum  = {1'b0, produced_r} + 34'(tok_size);
  assign would_ovf = size_sum > {2'b00, declared_r};

  // Copy source trails the write position by the distance.
  assign rd_addr = pos_r - HIST_AW'(dist_r);
  assign hist_we = cmd.cp_emit || cmd.run_emit || cmd.lit_emit;

  // An entry never written since the stream began reads as zero.
  always_comb begin
    if (cmd.cp_emit) begin
      emit_byte = rd_valid_r ? rd_data : 8'd0;
    end else begin
      emit_byte = byte_r;
    end
  end

  // Final status, evaluated after the last byte has been processed.
  always_comb begin
    if (ovf_r) begin
      fin_status = ST_OVERRUN;
    end else if (phase_r != PH_TOK_LO) begin
      fin_status = ST_TRUNC;
    end else if (produced_r == 33'd0 && declared_r != 32'd0) begin
      fin_status = ST_EMPTY;
    end else begin
      fin_status = ST_OK;
    end
  end

  lzt_ram #(
    .WIDTH (8),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (pos_r),
    .wdata (emit_byte),
    .re    (cmd.cp_rd),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Stream state update.
  always_comb begin
    phase_nxt    = phase_r;
    declared_nxt = declared_r;
    produced_nxt = produced_r;
    tok_lo_nxt   = tok_lo_r;
    run_len_nxt  = run_len_r;
    lit_left_nxt = lit_left_r;
    cp_left_nxt  = cp_left_r;
    dist_nxt     = dist_r;
    ovf_nxt      = ovf_r;
    pos_nxt      = pos_r;
    hvalid_nxt   = hvalid_r;

    if (cmd.step && !ovf_r) begin
      if (phase_r < PH_TOK_LO) begin
        declared_nxt[{phase_r[1:0], 3'b000} +: 8] =
          declared_r[{phase_r[1:0], 3'b000} +: 8] | byte_r;
        phase_nxt = phase_r + 3'd1;
      end else if (phase_r == PH_TOK_LO) begin
        tok_lo_nxt = byte_r;
        phase_nxt  = PH_TOK_HI;
      end else if (phase_r == PH_TOK_HI) begin
        if (would_ovf) begin
          ovf_nxt = 1'b1;
        end else if (is_run) begin
          produced_nxt = size_sum[32:0];
          run_len_nxt  = gap;
          phase_nxt    = PH_RUN;
        end else begin
          produced_nxt = size_sum[32:0];
          lit_left_nxt = cnt;
          cp_left_nxt  = len;
          dist_nxt     = 7'(gap) + 7'(len);
          phase_nxt    = (cnt != 5'd0) ? PH_LIT : PH_TOK_LO;
        end
      end else if (phase_r == PH_RUN) begin
        // A run of length zero still consumes its run byte.
        phase_nxt = PH_TOK_LO;
      end
    end

    // Every emitted data byte enters the history ring.
    if (hist_we) begin
      hvalid_nxt[pos_r] = 1'b1;
      pos_nxt           = pos_r + HIST_AW'(1);
    end

    if (cmd.cp_emit) begin
      cp_left_nxt = cp_left_r - 5'd1;
    end

    if (cmd.run_emit) begin
      run_len_nxt = run_len_r - 6'd1;
      if (run_len_r == 6'd1) begin
        phase_nxt = PH_TOK_LO;
      end
    end

    if (cmd.lit_emit) begin
      lit_left_nxt = lit_left_r - 5'd1;
      if (lit_left_r == 5'd1) begin
        phase_nxt = PH_TOK_LO;
      end
    end

    // The status result ends the stream and returns all stream state to reset.
    if (cmd.stat_emit) begin
      phase_nxt    = PH_HDR0;
      declared_nxt = '0;
      produced_nxt = '0;
      tok_lo_nxt   = '0;
      run_len_nxt  = '0;
      lit_left_nxt = '0;
      cp_left_nxt  = '0;
      dist_nxt     = '0;
      ovf_nxt      = 1'b0;
      pos_nxt      = '0;
      hvalid_nxt   = '0;
    end
  end

  // Output register: loaded on an emit, drained when the sink takes it.
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (hist_we) begin
      out_nxt.out_byte = emit_byte;
      out_nxt.is_data  = 1'b1;
      out_nxt.status   = ST_OK;
      out_nxt.run_end  = !last_r && ((cmd.cp_emit && cp_left_r == 5'd1) ||
                                     (cmd.run_emit && run_len_r == 6'd1) ||
                                     cmd.lit_emit);
      out_valid_nxt    = 1'b1;
    end else if (cmd.stat_emit) begin
      out_nxt.out_byte = 8'd0;
      out_nxt.is_data  = 1'b0;
      out_nxt.status   = fin_status;
      out_nxt.run_end  = 1'b1;
      out_valid_nxt    = 1'b1;
    end
  end

  // Control and stream state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      declared_r  <= '0;
      produced_r  <= '0;
      tok_lo_r    <= '0;
      run_len_r   <= '0;
      lit_left_r  <= '0;
      cp_left_r   <= '0;
      dist_r      <= '0;
      ovf_r       <= 1'b0;
      pos_r       <= '0;
      hvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      declared_r  <= declared_nxt;
      produced_r  <= produced_nxt;
      tok_lo_r    <= tok_lo_nxt;
      run_len_r   <= run_len_nxt;
      lit_left_r  <= lit_left_nxt;
      cp_left_r   <= cp_left_nxt;
      dist_r      <= dist_nxt;
      ovf_r       <= ovf_nxt;
      pos_r       <= pos_nxt;
      hvalid_r    <= hvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      byte_r <= in_payload.in_byte;
      last_r <= in_payload.is_last;
    end
    if (cmd.cp_rd) begin
      rd_valid_r <= hvalid_r[rd_addr];
    end
    out_r <= out_nxt;
  end

  // Status toward the controller.
  always_comb begin
    sts.phase     = phase_r;
    sts.overrun   = ovf_r;
    sts.tok_copy  = (phase_r == PH_TOK_HI) && !would_ovf && !is_run && (len != 5'd0);
    sts.run_zero  = (run_len_r == 6'd0);
    sts.run_last  = (run_len_r == 6'd1);
    sts.cp_last   = (cp_left_r == 5'd1);
    sts.last      = last_r;
    sts.slot_free = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

// ----- rtl/lzt_checker.sv -----
// ----------------------------------------------------------------------------
// lzt_checker
// Port-level checks for the LZSS token decompressor, bound to the top level.
// ----------------------------------------------------------------------------
module lzt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input lzt_pkg::lzt_in_t  in_payload,
  input logic              out_valid,
  input logic              out_ready,
  input lzt_pkg::lzt_out_t out_payload
);
  import lzt_pkg::*;

  // A stalled output request holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("output request changed while stalled");

  // A status result carries a zero byte and always closes its request.
  a_stat_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.is_data |-> out_payload.run_end &&
      out_payload.out_byte == 8'd0)
    else $error("malformed status result");

  // Data results carry an ok status.
  a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.is_data |-> out_payload.status == ST_OK)
    else $error("data result with nonzero status");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A new request is never taken while a result is being produced for a
  // request that was just accepted.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted in back-to-back cycles");

endmodule

bind lzss_token_decompressor lzt_checker u_lzt_checker (.*);
